### design/ffa_pkg.sv
package ffa_pkg;

    typedef enum logic [1:0] {
        STAT_PLACED    = 2'd0,
        STAT_COMPACTED = 2'd1,
        STAT_SKIPPED   = 2'd2,
        STAT_RELEASED  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_REL,
        S_SCAN,
        S_FILL,
        S_COMPACT,
        S_TAIL,
        S_DONE
    } state_t;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    localparam logic [7:0] FREE_OWNER = 8'd0;

    typedef struct packed {
        logic       mode;
        logic [7:0] owner;
        logic [8:0] size;
    } in_word_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] start_frame;
        logic [8:0] frames_moved;
    } out_word_t;

endpackage

### design/ffa_frame_ram.sv
module ffa_frame_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          ren,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (ren) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/ffa_ctrl.sv
module ffa_ctrl #(
    parameter int FRAMES = 256,
    parameter int AW     = 8,
    parameter int CW     = 9
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ffa_pkg::in_word_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ffa_pkg::out_word_t m_data,
    output logic              mem_we,
    output logic [AW-1:0]     mem_waddr,
    output logic [7:0]        mem_wdata,
    output logic              mem_ren,
    output logic [AW-1:0]     mem_raddr,
    input  logic [7:0]        mem_rdata
);

    import ffa_pkg::*;

    localparam int XW = (CW > 9) ? CW : 9;

    state_t    state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic      pv_reg, pv_next;
    logic [AW-1:0] pidx_reg, pidx_next;
    in_word_t  req_reg, req_next;
    logic [CW-1:0] free_cnt_reg, free_cnt_next;
    logic [CW-1:0] run_len_reg, run_len_next;
    logic [AW-1:0] run_start_reg, run_start_next;
    logic      found_reg, found_next;
    logic [AW-1:0] fit_start_reg, fit_start_next;
    logic      any_free_reg, any_free_next;
    logic [AW-1:0] first_free_reg, first_free_next;
    logic [CW-1:0] w_reg, w_next;
    logic [CW-1:0] moved_reg, moved_next;
    logic      hole_reg, hole_next;
    out_word_t res_reg, res_next;
    logic      m_valid_reg, m_valid_next;
    out_word_t m_data_reg, m_data_next;

    logic          sweep_done;
    logic [XW-1:0] size_x, free_x, fit_x, first_x, w_x, moved_x, tail_off_x, fill_x;
    logic [AW-1:0] run_start_eff;
    logic [CW-1:0] run_len_inc;

    assign size_x     = XW'(req_reg.size);
    assign free_x     = XW'(free_cnt_reg);
    assign fit_x      = XW'(fit_start_reg);
    assign first_x    = XW'(first_free_reg);
    assign w_x        = XW'(w_reg);
    assign moved_x    = XW'(moved_reg);
    assign tail_off_x = XW'(idx_reg - w_reg);
    assign fill_x     = XW'(idx_reg) + XW'(1);
    assign sweep_done = (idx_reg == CW'(FRAMES)) && !pv_reg;
    assign run_start_eff = (run_len_reg == '0) ? pidx_reg : run_start_reg;
    assign run_len_inc   = run_len_reg + CW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            idx_reg     <= '0;
            pv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            pv_reg      <= pv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pidx_reg       <= pidx_next;
        req_reg        <= req_next;
        free_cnt_reg   <= free_cnt_next;
        run_len_reg    <= run_len_next;
        run_start_reg  <= run_start_next;
        found_reg      <= found_next;
        fit_start_reg  <= fit_start_next;
        any_free_reg   <= any_free_next;
        first_free_reg <= first_free_next;
        w_reg          <= w_next;
        moved_reg      <= moved_next;
        hole_reg       <= hole_next;
        res_reg        <= res_next;
        m_data_reg     <= m_data_next;
    end

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        pv_next         = pv_reg;
        pidx_next       = pidx_reg;
        req_next        = req_reg;
        free_cnt_next   = free_cnt_reg;
        run_len_next    = run_len_reg;
        run_start_next  = run_start_reg;
        found_next      = found_reg;
        fit_start_next  = fit_start_reg;
        any_free_next   = any_free_reg;
        first_free_next = first_free_reg;
        w_next          = w_reg;
        moved_next      = moved_reg;
        hole_next       = hole_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        s_ready         = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg[AW-1:0];
        mem_wdata       = FREE_OWNER;
        mem_ren         = 1'b0;
        mem_raddr       = idx_reg[AW-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // issue one map read per cycle during sweeps; data returns in the following cycle
        if (state_reg == S_REL || state_reg == S_SCAN || state_reg == S_COMPACT) begin
            if (idx_reg != CW'(FRAMES)) begin
                mem_ren   = 1'b1;
                idx_next  = idx_reg + CW'(1);
                pv_next   = 1'b1;
                pidx_next = idx_reg[AW-1:0];
            end else begin
                pv_next = 1'b0;
            end
        end

        case (state_reg)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (idx_reg == CW'(FRAMES - 1)) begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next        = s_data;
                    idx_next        = '0;
                    pv_next         = 1'b0;
                    free_cnt_next   = '0;
                    run_len_next    = '0;
                    run_start_next  = '0;
                    found_next      = 1'b0;
                    fit_start_next  = '0;
                    any_free_next   = 1'b0;
                    first_free_next = '0;
                    state_next = (s_data.mode == MODE_RELEASE) ? S_REL : S_SCAN;
                end
            end
            S_REL: begin
                if (pv_reg && mem_rdata == req_reg.owner) begin
                    mem_we    = 1'b1;
                    mem_waddr = pidx_reg;
                end
                if (sweep_done) begin
                    res_next.status       = STAT_RELEASED;
                    res_next.start_frame  = '0;
                    res_next.frames_moved = '0;
                    state_next = S_DONE;
                end
            end
            S_SCAN: begin
                if (pv_reg) begin
                    if (mem_rdata == FREE_OWNER) begin
                        free_cnt_next  = free_cnt_reg + CW'(1);
                        run_start_next = run_start_eff;
                        run_len_next   = run_len_inc;
                        if (!found_reg && XW'(run_len_inc) >= size_x) begin
                            found_next     = 1'b1;
                            fit_start_next = run_start_eff;
                        end
                        if (!any_free_reg) begin
                            any_free_next   = 1'b1;
                            first_free_next = pidx_reg;
                        end
                    end else begin
                        run_len_next = '0;
                    end
                end
                if (sweep_done) begin
                    res_next.frames_moved = '0;
                    res_next.start_frame  = '0;
                    idx_next = '0;
                    if (size_x > free_x) begin
                        res_next.status = STAT_SKIPPED;
                        state_next      = S_DONE;
                    end else if (req_reg.size == '0) begin
                        res_next.status      = STAT_PLACED;
                        res_next.start_frame = first_x[7:0];
                        state_next           = S_DONE;
                    end else if (found_reg) begin
                        res_next.status      = STAT_PLACED;
                        res_next.start_frame = fit_x[7:0];
                        state_next           = S_FILL;
                    end else begin
                        pv_next    = 1'b0;
                        w_next     = '0;
                        moved_next = '0;
                        hole_next  = 1'b0;
                        state_next = S_COMPACT;
                    end
                end
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = fit_start_reg + idx_reg[AW-1:0];
                mem_wdata = req_reg.owner;
                if (fill_x == size_x) begin
                    state_next = S_DONE;
                end else begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_COMPACT: begin
                // write slot always trails the read pointer, so no overlap
                if (pv_reg) begin
                    if (mem_rdata != FREE_OWNER) begin
                        mem_we    = 1'b1;
                        mem_waddr = w_reg[AW-1:0];
                        mem_wdata = mem_rdata;
                        w_next    = w_reg + CW'(1);
                        if (hole_reg) begin
                            moved_next = moved_reg + CW'(1);
                        end
                    end else begin
                        hole_next = 1'b1;
                    end
                end
                if (sweep_done) begin
                    res_next.status       = STAT_COMPACTED;
                    res_next.start_frame  = w_x[7:0];
                    res_next.frames_moved = moved_x[8:0];
                    idx_next   = w_reg;
                    state_next = S_TAIL;
                end
            end
            S_TAIL: begin
                mem_we    = 1'b1;
                mem_wdata = (tail_off_x < size_x) ? req_reg.owner : FREE_OWNER;
                if (idx_reg == CW'(FRAMES - 1)) begin
                    state_next = S_DONE;
                end else begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### design/first_fit_frame_allocator_top.sv
// A request first sweeps the frame map; a fitting nonzero allocate then writes its run,
// and compaction adds a second sweep and rewrites all frames above the packed ones.
// Throughput: one request at a time; each request sweeps the frame map through
// the single memory read port, one frame per cycle.
// Reset: synchronous active-low; afterwards a clearing pass writes every frame free,
// and no request is accepted until it ends.
module first_fit_frame_allocator_top #(
    parameter int FRAMES = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ffa_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ffa_pkg::out_word_t m_data
);

    import ffa_pkg::*;

    localparam int AW = $clog2(FRAMES);
    localparam int CW = $clog2(FRAMES + 1);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_ren;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    ffa_ctrl #(
        .FRAMES(FRAMES),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .mem_we   (mem_we),
        .mem_waddr(mem_waddr),
        .mem_wdata(mem_wdata),
        .mem_ren  (mem_ren),
        .mem_raddr(mem_raddr),
        .mem_rdata(mem_rdata)
    );

    ffa_frame_ram #(
        .DEPTH(FRAMES),
        .AW   (AW)
    ) u_ram (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .ren  (mem_ren),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

`ifndef SYNTHESIS
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("request accepted during clearing pass");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word accepted while request in flight");

    a_release_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STAT_RELEASED || m_data.status == STAT_SKIPPED)
        |-> m_data.start_frame == 8'd0 && m_data.frames_moved == 9'd0)
        else $error("release or skip word carries frame fields");

    a_placed_no_move: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STAT_PLACED |-> m_data.frames_moved == 9'd0)
        else $error("placed word reports moved frames");
`endif

endmodule

### test/frame_map_checker.sv
`timescale 1ns / 100ps

module frame_map_checker #(
    parameter int FRAMES = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  ffa_pkg::in_word_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  ffa_pkg::out_word_t m_data,
    output int                 mismatches,
    output int                 outstanding
);

    import ffa_pkg::*;

    logic [7:0] frame_map [FRAMES];
    out_word_t  awaited_outcomes [$];
    int         err_total = 0;
    int         queue_depth = 0;

    assign mismatches  = err_total;
    assign outstanding = queue_depth;

    task automatic flag_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_total++;
    endtask

    // Apply one request to the local frame map and return the word it should produce.
    function automatic out_word_t allocate_or_release(input in_word_t req);
        out_word_t res;
        int        free_frames;
        int        idx;
        int        run_base;
        int        packed_top;
        int        moved;
        bit        hole_seen;
        res.status       = STAT_RELEASED;
        res.start_frame  = '0;
        res.frames_moved = '0;
        if (req.mode == MODE_RELEASE) begin
            for (idx = 0; idx < FRAMES; idx++)
                if (frame_map[idx] == req.owner) frame_map[idx] = FREE_OWNER;
            return res;
        end
        free_frames = 0;
        for (idx = 0; idx < FRAMES; idx++)
            if (frame_map[idx] == FREE_OWNER) free_frames++;
        if (int'(req.size) > free_frames) begin
            res.status = STAT_SKIPPED;
            return res;
        end
        res.status = STAT_PLACED;
        if (req.size == 9'd0) begin
            // zero-length request reports the lowest free frame, or 0 on a full map
            for (idx = 0; idx < FRAMES; idx++) begin
                if (frame_map[idx] == FREE_OWNER) begin
                    res.start_frame = idx[7:0];
                    break;
                end
            end
            return res;
        end
        idx = 0;
        while (idx < FRAMES) begin
            if (frame_map[idx] != FREE_OWNER) begin
                idx++;
            end else begin
                run_base = idx;
                while (idx < FRAMES && frame_map[idx] == FREE_OWNER) idx++;
                if (idx - run_base >= int'(req.size)) begin
                    for (int f = run_base; f < run_base + int'(req.size) && f < FRAMES; f++)
                        frame_map[f] = req.owner;
                    res.start_frame = run_base[7:0];
                    return res;
                end
            end
        end
        // no run fits: pack owned frames toward frame 0, keep their order
        packed_top = 0;
        moved      = 0;
        hole_seen  = 1'b0;
        for (idx = 0; idx < FRAMES; idx++) begin
            if (frame_map[idx] != FREE_OWNER) begin
                if (hole_seen) moved++;
                frame_map[packed_top] = frame_map[idx];
                packed_top++;
            end else begin
                hole_seen = 1'b1;
            end
        end
        for (idx = packed_top; idx < FRAMES; idx++) frame_map[idx] = FREE_OWNER;
        for (idx = packed_top; idx < packed_top + int'(req.size) && idx < FRAMES; idx++)
            frame_map[idx] = req.owner;
        res.status       = STAT_COMPACTED;
        res.start_frame  = packed_top[7:0];
        res.frames_moved = moved[8:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            for (int f = 0; f < FRAMES; f++) frame_map[f] = FREE_OWNER;
            awaited_outcomes.delete();
        end else begin
            // compare the outgoing word first: it always belongs to an older request
            if (m_valid && m_ready) begin
                if (awaited_outcomes.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result word %h", m_data));
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (m_data.status !== want.status)
                        flag_mismatch($sformatf("status got %0d want %0d",
                                                m_data.status, want.status));
                    if (m_data.start_frame !== want.start_frame)
                        flag_mismatch($sformatf("start_frame got %0d want %0d",
                                                m_data.start_frame, want.start_frame));
                    if (m_data.frames_moved !== want.frames_moved)
                        flag_mismatch($sformatf("frames_moved got %0d want %0d",
                                                m_data.frames_moved, want.frames_moved));
                end
            end
            if (s_valid && s_ready)
                awaited_outcomes.insert(awaited_outcomes.size(), allocate_or_release(s_data));
        end
        queue_depth = awaited_outcomes.size();
    end

endmodule

### test/first_fit_frame_allocator_top_tb.sv
`timescale 1ns / 100ps

module first_fit_frame_allocator_top_tb;

    import ffa_pkg::*;

    localparam int FRAMES       = 256;
    localparam int RANDOM_WORDS = 1228;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b1;
    out_word_t m_data;
    int        mismatches;
    int        outstanding;
    int        ready_hold = 0;

    always #2 aclk = ~aclk;

    first_fit_frame_allocator_top #(
        .FRAMES (FRAMES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    frame_map_checker #(
        .FRAMES (FRAMES)
    ) checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Alternate ready and stalled stretches of random length.
    always @(negedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold--;
        end else begin
            m_ready    = ~m_ready;
            ready_hold = m_ready ? $urandom_range(0, 60) : $urandom_range(0, 20);
        end
    end

    // Hold the word until it is taken, then step to the next falling edge.
    task automatic send_word(input in_word_t w);
        s_data  = w;
        s_valid = 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic in_word_t random_request();
        in_word_t req;
        int       pick;
        pick     = $urandom_range(0, 99);
        req.mode = (pick < 27) ? MODE_RELEASE : MODE_ALLOC;
        pick     = $urandom_range(0, 99);
        // a small owner pool keeps releases hitting live runs and fragments the map
        if (pick < 85)      req.owner = 8'($urandom_range(1, 12));
        else if (pick < 96) req.owner = 8'($urandom_range(13, 255));
        else                req.owner = FREE_OWNER;
        pick = $urandom_range(0, 99);
        if (pick < 2)       req.size = 9'd0;
        else if (pick < 70) req.size = 9'($urandom_range(1, 24));
        else if (pick < 90) req.size = 9'($urandom_range(25, 96));
        else if (pick < 97) req.size = 9'($urandom_range(97, 256));
        else                req.size = 9'($urandom_range(257, 511));
        return req;
    endfunction

    initial begin
        int burst;
        int words_left;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        send_word('{MODE_ALLOC,   8'd1,   9'd0});
        send_word('{MODE_ALLOC,   8'd255, 9'd256});
        send_word('{MODE_ALLOC,   8'd2,   9'd0});
        send_word('{MODE_ALLOC,   8'd2,   9'd1});
        send_word('{MODE_RELEASE, 8'd255, 9'd511});
        send_word('{MODE_ALLOC,   8'd0,   9'd5});
        send_word('{MODE_RELEASE, 8'd0,   9'd0});
        send_word('{MODE_ALLOC,   8'd1,   9'd10});
        send_word('{MODE_ALLOC,   8'd2,   9'd10});
        send_word('{MODE_ALLOC,   8'd1,   9'd10});
        send_word('{MODE_ALLOC,   8'd3,   9'd200});
        send_word('{MODE_RELEASE, 8'd2,   9'd0});
        send_word('{MODE_ALLOC,   8'd4,   9'd30});
        send_word('{MODE_ALLOC,   8'd5,   9'd511});
        send_word('{MODE_ALLOC,   8'd5,   9'd300});
        send_word('{MODE_RELEASE, 8'd1,   9'd0});
        send_word('{MODE_RELEASE, 8'd3,   9'd0});
        send_word('{MODE_RELEASE, 8'd4,   9'd0});
        send_word('{MODE_RELEASE, 8'd5,   9'd0});
        send_word('{MODE_ALLOC,   8'd128, 9'd1});
        send_word('{MODE_ALLOC,   8'd127, 9'd255});
        send_word('{MODE_RELEASE, 8'd128, 9'd0});
        send_word('{MODE_RELEASE, 8'd127, 9'd256});
        s_valid = 1'b0;

        words_left = RANDOM_WORDS;
        while (words_left > 0) begin
            burst = $urandom_range(1, 24);
            if (burst > words_left) burst = words_left;
            repeat (burst) send_word(random_request());
            words_left -= burst;
            // drop valid for a gap, short mostly, now and then longer than a request
            if ($urandom_range(0, 3) != 0) begin
                s_valid = 1'b0;
                if ($urandom_range(0, 4) == 0) repeat ($urandom_range(13, 400)) @(negedge aclk);
                else repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
        end
        s_valid = 1'b0;

        while (outstanding != 0) @(negedge aclk);
        repeat (3 * FRAMES + 16) @(negedge aclk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #25_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### first_fit_frame_allocator_top.f
design/ffa_pkg.sv
design/ffa_frame_ram.sv
design/ffa_ctrl.sv
design/first_fit_frame_allocator_top.sv
test/frame_map_checker.sv
test/first_fit_frame_allocator_top_tb.sv
